[sv/slab_slot_allocator_defines.svh]
// Assertion macros for the slab slot allocator.
`ifndef SLAB_SLOT_ALLOCATOR_DEFINES_SVH
`define SLAB_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define SSA_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Checked at every edge, reset included.
`define SSA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define SSA_ASSERT(lbl, ck, rs, prop, msg)
`define SSA_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

[sv/ssa_pkg.sv]
`timescale 1ns / 1ps

package ssa_pkg;

  localparam int MAX_SLOTS_DEF   = 1024;
  localparam int OFFSET_BITS_DEF = 22;

  // Config register widths
  localparam int SLOT_W  = 13;
  localparam int SLOTS_W = 11;

  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_W     = $clog2(ALIGN_BYTES);

  localparam logic [SLOT_W-1:0]  SLOT_BYTES_RST = SLOT_W'(8);
  localparam logic [SLOTS_W-1:0] INIT_SLOTS_RST = SLOTS_W'(64);
  localparam logic [SLOTS_W-1:0] CAP_SLOTS_RST  = SLOTS_W'(1024);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OOM      = 2'd1,
    STAT_OUTSIDE  = 2'd2,
    STAT_MISALIGN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_SLOT_BYTES = 2'd0,
    REG_INIT_SLOTS = 2'd1,
    REG_CAP_SLOTS  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_DIV,
    S_FREE_END,
    S_FIN
  } state_t;

  // Slot size with the low bits dropped; zero means the minimum slot.
  function automatic logic [SLOT_W-1:0] eff_slot(input logic [SLOT_W-1:0] sb);
    logic [SLOT_W-1:0] s;
    s = {sb[SLOT_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
    return (s != '0) ? s : SLOT_W'(ALIGN_BYTES);
  endfunction

endpackage

[sv/slab_slot_allocator.sv]
`timescale 1ns / 1ps
// Allocate runs S_MUL then S_FIN to the registered result (S_FIN alone when out of memory);
//   free runs S_MUL, S_CMP, the S_DIV steps of the bit-serial offset/slot-size divider,
//   S_FREE_END and S_FIN (S_MUL, S_CMP, S_FIN when the offset lies outside the region).
// Requests are taken one at a time, only in S_IDLE; a new one waits until the last result
//   leaves S_FIN, which waits while an earlier result is still held by m_tready low.
// Reset (rst, synchronous): registers to defaults, freed stack empty, counters zero,
//   committed slots from initial_slots; the link memory is not cleared.
module slab_slot_allocator #(
  parameter int MAX_SLOTS   = ssa_pkg::MAX_SLOTS_DEF,
  parameter int OFFSET_BITS = ssa_pkg::OFFSET_BITS_DEF
) (
  input  logic clk,
  input  logic rst,

  // Request stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [OFFSET_BITS-1:0] free_offset, zero fill above
  input  logic [((OFFSET_BITS+7)/8)*8-1:0]      s_tdata,
  // [0] cmd
  input  logic                                  s_tuser,

  // Result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // status[2], slot_offset[OFFSET_BITS], grew[1], in_use_count[CW],
  // committed_count[CW], zero fill (CW = clog2(MAX_SLOTS+1))
  output logic [((2*$clog2(MAX_SLOTS+1)+OFFSET_BITS+3+7)/8)*8-1:0] m_tdata,

  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W  = ssa_pkg::SLOT_W;
  localparam int SLOTS_W = ssa_pkg::SLOTS_W;
  localparam int OB      = OFFSET_BITS;
  localparam int IDX_W   = $clog2(MAX_SLOTS);
  localparam int CW      = $clog2(MAX_SLOTS + 1);
  localparam int CMPW    = (CW > SLOTS_W) ? CW : SLOTS_W;
  localparam int PW      = CW + SLOT_W;
  localparam int XW      = ((PW > OB) ? PW : OB) + 1;
  localparam int DCW     = $clog2(OB + 1);
  localparam int OUT_W   = ((2*CW + OB + 3 + 7) / 8) * 8;

  // Effective capacity: register value clamped to the slot count of the link memory.
  function automatic logic [CW-1:0] clamp_cap(input logic [SLOTS_W-1:0] c);
    logic [CMPW-1:0] cw;
    logic [CMPW-1:0] mw;
    cw = CMPW'(c);
    mw = CMPW'(MAX_SLOTS);
    return CW'((cw < mw) ? cw : mw);
  endfunction

  function automatic logic [CW-1:0] start_slots(input logic [SLOTS_W-1:0] init,
                                                input logic [CW-1:0] cap);
    logic [CMPW-1:0] iw;
    logic [CMPW-1:0] cw;
    iw = CMPW'(init);
    cw = CMPW'(cap);
    return CW'((iw < cw) ? iw : cw);
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  ssa_pkg::state_t state, state_next;

  // Config registers
  logic [SLOT_W-1:0]  slot_bytes, slot_bytes_next;
  logic [SLOTS_W-1:0] initial_slots, initial_slots_next;
  logic [SLOTS_W-1:0] capacity_slots, capacity_slots_next;

  // Allocator bookkeeping
  logic [IDX_W-1:0] freed_top, freed_top_next;
  logic [CW-1:0]    freed_len, freed_len_next;
  logic [CW-1:0]    fresh_index, fresh_index_next;
  logic [CW-1:0]    committed, committed_next;
  logic [CW-1:0]    in_use, in_use_next;

  // Per-request working registers
  ssa_pkg::cmd_t    cmd_q, cmd_q_next;
  logic [OB-1:0]    off_q, off_q_next;
  logic [IDX_W-1:0] idx_q, idx_q_next;
  logic             pop_q, pop_q_next;
  logic             have_q, have_q_next;
  logic             grew_q, grew_q_next;
  ssa_pkg::status_t status_q, status_q_next;
  logic [PW-1:0]    prod_q, prod_q_next;
  logic [SLOT_W-1:0] rem_q, rem_q_next;
  logic [IDX_W-1:0] q_q, q_q_next;
  logic [DCW-1:0]   div_cnt, div_cnt_next;

  // Output register
  ssa_pkg::status_t out_status, out_status_next;
  logic [OB-1:0]    out_offset, out_offset_next;
  logic             out_grew, out_grew_next;
  logic [CW-1:0]    out_in_use, out_in_use_next;
  logic [CW-1:0]    out_committed, out_committed_next;
  logic             m_tvalid_next;

  // Link memory: next_link[] of the freed LIFO
  logic [IDX_W-1:0] link_mem [MAX_SLOTS];
  logic [IDX_W-1:0] link_q;
  logic             link_re;
  logic             link_we;
  logic [IDX_W-1:0] link_raddr;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;

  // Datapath helpers
  logic [SLOT_W-1:0] s_eff;
  logic [CW-1:0]     cap;
  logic [CW:0]       grow_n;
  logic [CW-1:0]     mul_a;
  logic [SLOT_W:0]   trial;
  logic              qbit;
  logic              cfg_wr;
  logic              restart;
  logic              free_push;
  ssa_pkg::reg_idx_t cfg_idx;

  assign pready   = 1'b1;
  assign s_tready = (state == ssa_pkg::S_IDLE);
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = ssa_pkg::reg_idx_t'(paddr[3:2]);

  assign s_eff = ssa_pkg::eff_slot(slot_bytes);
  assign cap   = clamp_cap(capacity_slots);

  // Doubling step; an empty region grows to one slot.
  assign grow_n = (committed != '0) ? {committed, 1'b0} : (CW+1)'(1);

  // One shared multiplier: slot index * size on allocate, committed * size on free.
  assign mul_a = (cmd_q == ssa_pkg::CMD_FREE) ? committed : CW'(idx_q);

  // Restoring divider step, MSB of the offset first.
  assign trial = {rem_q, off_q[OB-1]};
  assign qbit  = (trial >= {1'b0, s_eff});

  // Aligned free about to be pushed
  assign free_push = (state == ssa_pkg::S_FREE_END) && (rem_q == '0);

  assign m_tdata = OUT_W'({out_committed, out_in_use, out_grew, out_offset, out_status});

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      ssa_pkg::REG_SLOT_BYTES: prdata = 32'(slot_bytes);
      ssa_pkg::REG_INIT_SLOTS: prdata = 32'(initial_slots);
      ssa_pkg::REG_CAP_SLOTS:  prdata = 32'(capacity_slots);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next          = state;
    slot_bytes_next     = slot_bytes;
    initial_slots_next  = initial_slots;
    capacity_slots_next = capacity_slots;
    freed_top_next      = freed_top;
    freed_len_next      = freed_len;
    fresh_index_next    = fresh_index;
    committed_next      = committed;
    in_use_next         = in_use;
    cmd_q_next          = cmd_q;
    off_q_next          = off_q;
    idx_q_next          = idx_q;
    pop_q_next          = pop_q;
    have_q_next         = have_q;
    grew_q_next         = grew_q;
    status_q_next       = status_q;
    prod_q_next         = prod_q;
    rem_q_next          = rem_q;
    q_q_next            = q_q;
    div_cnt_next        = div_cnt;
    out_status_next     = out_status;
    out_offset_next     = out_offset;
    out_grew_next       = out_grew;
    out_in_use_next     = out_in_use;
    out_committed_next  = out_committed;
    m_tvalid_next       = m_tvalid & ~m_tready;
    link_re             = 1'b0;
    link_raddr          = freed_top;
    link_we             = 1'b0;
    link_waddr          = q_q;
    link_wdata          = freed_top;
    restart             = 1'b0;

    // Any write to a mapped register restarts the allocator.
    if (cfg_wr) begin
      unique case (cfg_idx)
        ssa_pkg::REG_SLOT_BYTES: begin
          slot_bytes_next = pwdata[SLOT_W-1:0];
          restart         = 1'b1;
        end
        ssa_pkg::REG_INIT_SLOTS: begin
          initial_slots_next = pwdata[SLOTS_W-1:0];
          restart            = 1'b1;
        end
        ssa_pkg::REG_CAP_SLOTS: begin
          capacity_slots_next = pwdata[SLOTS_W-1:0];
          restart             = 1'b1;
        end
        default: ;
      endcase
    end

    unique case (state)
      ssa_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd_q_next    = ssa_pkg::cmd_t'(s_tuser);
          off_q_next    = s_tdata[OB-1:0];
          grew_q_next   = 1'b0;
          status_q_next = ssa_pkg::STAT_OK;
          pop_q_next    = 1'b0;
          have_q_next   = 1'b0;
          if (ssa_pkg::cmd_t'(s_tuser) == ssa_pkg::CMD_FREE) begin
            state_next = ssa_pkg::S_MUL;
          end else begin
            priority if (freed_len != '0) begin
              // pop: link of the top comes back next cycle
              idx_q_next     = freed_top;
              link_re        = 1'b1;
              freed_len_next = freed_len - CW'(1);
              pop_q_next     = 1'b1;
              have_q_next    = 1'b1;
            end else if (fresh_index < committed) begin
              idx_q_next       = IDX_W'(fresh_index);
              fresh_index_next = fresh_index + CW'(1);
              have_q_next      = 1'b1;
            end else if (committed < cap) begin
              committed_next   = (grow_n > (CW+1)'(cap)) ? cap : CW'(grow_n);
              grew_q_next      = 1'b1;
              idx_q_next       = IDX_W'(fresh_index);
              fresh_index_next = fresh_index + CW'(1);
              have_q_next      = 1'b1;
            end else begin
              status_q_next = ssa_pkg::STAT_OOM;
            end
            if (have_q_next) begin
              if (in_use < CW'(MAX_SLOTS)) begin
                in_use_next = in_use + CW'(1);
              end
              state_next = ssa_pkg::S_MUL;
            end else begin
              state_next = ssa_pkg::S_FIN;
            end
          end
        end
      end

      ssa_pkg::S_MUL: begin
        prod_q_next = PW'(mul_a) * PW'(s_eff);
        if (pop_q) begin
          freed_top_next = link_q;
        end
        state_next = (cmd_q == ssa_pkg::CMD_FREE) ? ssa_pkg::S_CMP : ssa_pkg::S_FIN;
      end

      ssa_pkg::S_CMP: begin
        if (XW'(off_q) >= XW'(prod_q)) begin
          status_q_next = ssa_pkg::STAT_OUTSIDE;
          state_next    = ssa_pkg::S_FIN;
        end else begin
          rem_q_next   = '0;
          q_q_next     = '0;
          div_cnt_next = DCW'(OB);
          state_next   = ssa_pkg::S_DIV;
        end
      end

      ssa_pkg::S_DIV: begin
        rem_q_next   = qbit ? SLOT_W'(trial - {1'b0, s_eff}) : SLOT_W'(trial);
        q_q_next     = IDX_W'({q_q, qbit});
        off_q_next   = off_q << 1;
        div_cnt_next = div_cnt - DCW'(1);
        if (div_cnt == DCW'(1)) begin
          state_next = ssa_pkg::S_FREE_END;
        end
      end

      ssa_pkg::S_FREE_END: begin
        if (rem_q != '0) begin
          status_q_next = ssa_pkg::STAT_MISALIGN;
        end else begin
          // push
          link_we        = 1'b1;
          freed_top_next = q_q;
          if (freed_len < CW'(MAX_SLOTS)) begin
            freed_len_next = freed_len + CW'(1);
          end
          if (in_use != '0) begin
            in_use_next = in_use - CW'(1);
          end
        end
        state_next = ssa_pkg::S_FIN;
      end

      ssa_pkg::S_FIN: begin
        if (!m_tvalid || m_tready) begin
          out_status_next    = status_q;
          out_offset_next    = (cmd_q == ssa_pkg::CMD_ALLOC && have_q) ? OB'(prod_q) : '0;
          out_grew_next      = grew_q;
          out_in_use_next    = in_use;
          out_committed_next = committed;
          m_tvalid_next      = 1'b1;
          state_next         = ssa_pkg::S_IDLE;
        end
      end

      default: state_next = ssa_pkg::S_IDLE;
    endcase

    if (restart) begin
      freed_top_next   = '0;
      freed_len_next   = '0;
      fresh_index_next = '0;
      in_use_next      = '0;
      committed_next   = start_slots(initial_slots_next, clamp_cap(capacity_slots_next));
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ssa_pkg::S_IDLE;
      slot_bytes     <= ssa_pkg::SLOT_BYTES_RST;
      initial_slots  <= ssa_pkg::INIT_SLOTS_RST;
      capacity_slots <= ssa_pkg::CAP_SLOTS_RST;
      freed_top      <= '0;
      freed_len      <= '0;
      fresh_index    <= '0;
      in_use         <= '0;
      committed      <= start_slots(ssa_pkg::INIT_SLOTS_RST,
                                    clamp_cap(ssa_pkg::CAP_SLOTS_RST));
      m_tvalid       <= 1'b0;
    end else begin
      state          <= state_next;
      slot_bytes     <= slot_bytes_next;
      initial_slots  <= initial_slots_next;
      capacity_slots <= capacity_slots_next;
      freed_top      <= freed_top_next;
      freed_len      <= freed_len_next;
      fresh_index    <= fresh_index_next;
      in_use         <= in_use_next;
      committed      <= committed_next;
      m_tvalid       <= m_tvalid_next;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    cmd_q         <= cmd_q_next;
    off_q         <= off_q_next;
    idx_q         <= idx_q_next;
    pop_q         <= pop_q_next;
    have_q        <= have_q_next;
    grew_q        <= grew_q_next;
    status_q      <= status_q_next;
    prod_q        <= prod_q_next;
    rem_q         <= rem_q_next;
    q_q           <= q_q_next;
    div_cnt       <= div_cnt_next;
    out_status    <= out_status_next;
    out_offset    <= out_offset_next;
    out_grew      <= out_grew_next;
    out_in_use    <= out_in_use_next;
    out_committed <= out_committed_next;
  end

  // Link memory, one write and one registered read per cycle. Requests are
  // handled one at a time, so a push always lands before the next pop reads.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_q <= link_mem[link_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "slab_slot_allocator_defines.svh"

  `SSA_ASSERT(a_fresh_in_region, clk, rst, fresh_index <= committed, "fresh index past committed")
  `SSA_ASSERT(a_quot_in_region, clk, rst, free_push |-> (CW'(q_q) < committed), "bad free index")
  `SSA_ASSERT(a_one_request, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "request while busy")
  `SSA_ASSERT_ALWAYS(a_rst_out_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int MAX  = ssa_pkg::MAX_SLOTS_DEF;
  localparam int OB   = ssa_pkg::OFFSET_BITS_DEF;
  localparam int CW   = $clog2(ssa_pkg::MAX_SLOTS_DEF + 1);
  localparam int IN_W = ((OB + 7) / 8) * 8;
  localparam int RS_W = ((2 * CW + OB + 3 + 7) / 8) * 8;

  // Register index past the end of the map; a write there must change nothing.
  localparam int REG_SPARE = 3;
  // Receiver hold-off used to back the block up into its request port.
  localparam int LONG_HOLD = 300;
  // Idle cycles after a drain; longer than a free takes, with margin.
  localparam int SETTLE = 40;

  // Gap modes for each side of the stream.
  localparam int GAP_NONE  = 0;
  localparam int GAP_FULL  = 1;
  localparam int GAP_RARE  = 2;

  typedef struct packed {
    ssa_pkg::cmd_t cmd;
    logic [OB-1:0] off;
  } req_t;

  typedef struct packed {
    ssa_pkg::status_t status;
    logic [OB-1:0]    slot_off;
    logic             grew;
    logic [CW-1:0]    in_use;
    logic [CW-1:0]    committed;
  } outcome_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  // [21:0] free_offset, [23:22] zero
  logic [IN_W-1:0] s_tdata = '0;
  // [0] cmd
  logic            s_tuser = 1'b0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  // [1:0] status, [23:2] slot_offset, [24] grew, [35:25] in_use_count,
  // [46:36] committed_count, [47] zero
  logic [RS_W-1:0] m_tdata;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [3:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  slab_slot_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow allocator: registers plus the same bookkeeping the block keeps.
  // ---------------------------------------------------------------------------
  logic [12:0]  sh_slot_bytes;
  logic [10:0]  sh_init;
  logic [10:0]  sh_cap;
  int unsigned  link_mem [MAX];
  int unsigned  sh_top, sh_flen, sh_fresh, sh_committed, sh_in_use;

  req_t          pending_q [$];   // requests waiting for the driver
  outcome_t      outcome_q [$];   // outcomes owed by the block, oldest first
  logic [OB-1:0] granted [$];     // offsets handed out, candidates for frees

  int err_count = 0;
  int tx_mode = GAP_NONE;
  int rx_mode = GAP_NONE;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic longint unsigned eff_size();
    logic [12:0] s;
    s = {sh_slot_bytes[12:3], 3'b000};
    return (s != 0) ? longint'(s) : longint'(ssa_pkg::ALIGN_BYTES);
  endfunction

  function automatic int unsigned cap_slots();
    return (sh_cap < MAX) ? sh_cap : MAX;
  endfunction

  // Any mapped register write, like reset, empties the freed stack and zeroes counters.
  function automatic void restart_shadow();
    int unsigned cap;
    cap = cap_slots();
    sh_top = MAX;
    sh_flen = 0;
    sh_fresh = 0;
    sh_in_use = 0;
    sh_committed = (sh_init < cap) ? sh_init : cap;
    granted.delete();
  endfunction

  function automatic void apply_reg(int idx, logic [31:0] v);
    if (idx == ssa_pkg::REG_SLOT_BYTES) begin
      sh_slot_bytes = v[12:0];
    end else if (idx == ssa_pkg::REG_INIT_SLOTS) begin
      sh_init = v[10:0];
    end else if (idx == ssa_pkg::REG_CAP_SLOTS) begin
      sh_cap = v[10:0];
    end else begin
      return;
    end
    restart_shadow();
  endfunction

  function automatic logic [31:0] reg_value(int idx);
    if (idx == ssa_pkg::REG_SLOT_BYTES) return 32'(sh_slot_bytes);
    if (idx == ssa_pkg::REG_INIT_SLOTS) return 32'(sh_init);
    return 32'(sh_cap);
  endfunction

  // Runs one request through the shadow allocator and returns what the block owes.
  function automatic outcome_t book_request(req_t r);
    outcome_t          o;
    longint unsigned   s;
    int unsigned       cap, idx, grown;
    bit                have;
    s = eff_size();
    cap = cap_slots();
    have = 1'b0;
    idx = 0;
    o.status = ssa_pkg::STAT_OK;
    o.slot_off = '0;
    o.grew = 1'b0;
    if (r.cmd == ssa_pkg::CMD_ALLOC) begin
      if (sh_flen > 0) begin
        // LIFO reuse of freed slots first
        idx = sh_top;
        if (idx < MAX) sh_top = link_mem[idx];
        sh_flen--;
        have = 1'b1;
      end else if (sh_fresh < sh_committed) begin
        idx = sh_fresh++;
        have = 1'b1;
      end else if (sh_committed < cap) begin
        // double the committed slots, zero grows to one
        grown = (sh_committed != 0) ? sh_committed * 2 : 1;
        sh_committed = (grown > cap) ? cap : grown;
        o.grew = 1'b1;
        idx = sh_fresh++;
        have = 1'b1;
      end else begin
        o.status = ssa_pkg::STAT_OOM;
      end
      if (have) begin
        o.slot_off = OB'(longint'(idx) * s);   // wraps past the offset width
        if (sh_in_use < MAX) sh_in_use++;
        granted.push_back(o.slot_off);
      end
    end else begin
      if (longint'(r.off) >= longint'(sh_committed) * s) begin
        o.status = ssa_pkg::STAT_OUTSIDE;
      end else if (longint'(r.off) % s != 0) begin
        o.status = ssa_pkg::STAT_MISALIGN;
      end else begin
        // double frees and never-used slots are pushed all the same
        idx = 32'(longint'(r.off) / s);
        if (idx < MAX) begin
          link_mem[idx] = sh_top;
          sh_top = idx;
          if (sh_flen < MAX) sh_flen++;
          if (sh_in_use > 0) sh_in_use--;
        end
      end
    end
    o.in_use = CW'(sh_in_use);
    o.committed = CW'(sh_committed);
    return o;
  endfunction

  function automatic int draw_gap(int mode);
    case (mode)
      GAP_FULL: return $urandom_range(0, 17);
      GAP_RARE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
      default:  return 0;
    endcase
  endfunction

  task automatic report(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: one NBA per signal per edge; gap drawn at each acceptance.
  // ---------------------------------------------------------------------------
  req_t cur_req;
  int   tx_wait = 0;

  always @(posedge clk) begin : req_driver
    int   w;
    req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
      tx_wait <= 0;
    end else begin
      w = tx_wait;
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(book_request(cur_req));
        w = draw_gap(tx_mode);
      end
      // keep holding a request the block has not taken
      if (!(s_tvalid && !s_tready)) begin
        if (w == 0 && pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          cur_req <= nxt;
          s_tvalid <= 1'b1;
          s_tdata <= IN_W'(nxt.off);
          s_tuser <= nxt.cmd;
        end else begin
          s_tvalid <= 1'b0;
          if (w > 0) w--;
        end
      end
      tx_wait <= w;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares every accepted result with the oldest outcome.
  // ---------------------------------------------------------------------------
  int rx_wait = 0;

  always @(posedge clk) begin : result_monitor
    int       w;
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = outcome_q.pop_front();
          check_field("status", m_tdata[1:0], want.status);
          check_field("slot_offset", m_tdata[23:2], want.slot_off);
          check_field("grew", m_tdata[24], want.grew);
          check_field("in_use_count", m_tdata[35:25], want.in_use);
          check_field("committed_count", m_tdata[46:36], want.committed);
        end
        w = draw_gap(rx_mode);
      end else if (w > 0) begin
        w--;
      end
      rx_wait <= w;
      m_tready <= (w == 0) && (hold_left == 0);
    end
  end

  // Long receiver stall, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic apb_access(input int idx, input bit wr, input logic [31:0] v,
                            output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 4'(idx * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called with the block idle; reads back mapped registers.
  task automatic cfg_write(input int idx, input logic [31:0] v);
    logic [31:0] rd;
    apb_access(idx, 1'b1, v, rd);
    apply_reg(idx, v);
    if (idx < REG_SPARE) begin
      apb_access(idx, 1'b0, '0, rd);
      check_field($sformatf("register %0d readback", idx), rd, reg_value(idx));
    end
  endtask

  task automatic send(input ssa_pkg::cmd_t c, input logic [OB-1:0] off);
    req_t r;
    r.cmd = c;
    r.off = off;
    while (pending_q.size() >= 3) @(negedge clk);
    pending_q.push_back(r);
  endtask

  // Wait for every request to be answered, then let the block settle.
  task automatic drain();
    @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || outcome_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Frees lean on offsets actually handed out so the freed stack gets real depth.
  function automatic logic [OB-1:0] pick_free_offset();
    int              r, k;
    longint unsigned s, c;
    logic [OB-1:0]   o;
    r = $urandom_range(0, 99);
    s = eff_size();
    c = (sh_committed > 0) ? sh_committed : 1;
    if (r < 70 && granted.size() > 0) begin
      k = $urandom_range(0, granted.size() - 1);
      o = granted[k];
      granted.delete(k);
    end else if (r < 80) begin
      o = OB'(longint'($urandom_range(0, c - 1)) * s);
    end else if (r < 90) begin
      o = OB'(longint'($urandom_range(0, c - 1)) * s
              + $urandom_range(1, ssa_pkg::ALIGN_BYTES - 1));
    end else begin
      o = OB'($urandom());
    end
    return o;
  endfunction

  task automatic run_random(input int n, input int alloc_pct);
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < alloc_pct) send(ssa_pkg::CMD_ALLOC, OB'($urandom()));
      else send(ssa_pkg::CMD_FREE, pick_free_offset());
    end
  endtask

  task automatic set_modes(input int tx, input int rx);
    @(negedge clk);
    tx_mode = tx;
    rx_mode = rx;
  endtask

  initial begin
    sh_slot_bytes = ssa_pkg::SLOT_BYTES_RST;
    sh_init = ssa_pkg::INIT_SLOTS_RST;
    sh_cap = ssa_pkg::CAP_SLOTS_RST;
    restart_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset configuration: 8-byte slots, 64 committed.
    set_modes(GAP_NONE, GAP_FULL);
    send(ssa_pkg::CMD_ALLOC, '0);
    send(ssa_pkg::CMD_ALLOC, '1);          // offset ignored on allocate
    send(ssa_pkg::CMD_FREE, OB'(8));
    send(ssa_pkg::CMD_FREE, OB'(8));       // double free still pushes
    send(ssa_pkg::CMD_FREE, OB'(504));     // last committed slot, never handed out
    send(ssa_pkg::CMD_FREE, OB'(512));     // first byte past the region
    send(ssa_pkg::CMD_FREE, '1);           // top of the offset field
    send(ssa_pkg::CMD_FREE, OB'(4));       // inside, misaligned
    send(ssa_pkg::CMD_ALLOC, '0);          // pops the freed stack in LIFO order
    send(ssa_pkg::CMD_ALLOC, '0);
    send(ssa_pkg::CMD_ALLOC, '0);
    send(ssa_pkg::CMD_ALLOC, '0);          // stack empty, back to fresh slots
    send(ssa_pkg::CMD_FREE, OB'(22'h2AAAA8));
    drain();

    // Zero capacity: nothing committed, every allocate runs out.
    cfg_write(ssa_pkg::REG_CAP_SLOTS, 32'd0);
    send(ssa_pkg::CMD_ALLOC, '0);
    send(ssa_pkg::CMD_FREE, '0);
    drain();

    // Zero slot size falls back to eight; growth from zero up to a capacity of 5.
    set_modes(GAP_FULL, GAP_NONE);
    cfg_write(ssa_pkg::REG_SLOT_BYTES, 32'd0);
    cfg_write(ssa_pkg::REG_INIT_SLOTS, 32'd0);
    cfg_write(ssa_pkg::REG_CAP_SLOTS, 32'd5);
    repeat (7) send(ssa_pkg::CMD_ALLOC, '0);
    send(ssa_pkg::CMD_FREE, OB'(40));
    send(ssa_pkg::CMD_FREE, OB'(36));
    drain();

    // Largest fields with junk above them; slot offsets wrap past 22 bits.
    set_modes(GAP_FULL, GAP_FULL);
    cfg_write(ssa_pkg::REG_SLOT_BYTES, 32'hFFFF_FFFF);
    cfg_write(ssa_pkg::REG_INIT_SLOTS, 32'hFFFF_FFFF);
    cfg_write(ssa_pkg::REG_CAP_SLOTS, 32'hFFFF_FFFF);
    run_random(450, 85);
    drain();

    // Small odd-sized region: growth, out of memory, then the unmapped write.
    set_modes(GAP_NONE, GAP_NONE);
    cfg_write(ssa_pkg::REG_SLOT_BYTES, 32'd24);
    cfg_write(ssa_pkg::REG_INIT_SLOTS, 32'd1);
    cfg_write(ssa_pkg::REG_CAP_SLOTS, 32'd40);
    run_random(150, 55);
    drain();
    cfg_write(REG_SPARE, $urandom());   // state must carry over untouched
    set_modes(GAP_RARE, GAP_FULL);
    run_random(150, 55);
    drain();

    set_modes(GAP_FULL, GAP_RARE);
    cfg_write(ssa_pkg::REG_SLOT_BYTES, 32'd4096);
    cfg_write(ssa_pkg::REG_INIT_SLOTS, 32'd1024);
    cfg_write(ssa_pkg::REG_CAP_SLOTS, 32'd1024);
    run_random(250, 50);
    drain();

    // Unaligned size register; long receiver stall while requests keep coming.
    set_modes(GAP_NONE, GAP_NONE);
    cfg_write(ssa_pkg::REG_SLOT_BYTES, 32'd7);
    cfg_write(ssa_pkg::REG_INIT_SLOTS, 32'd3);
    cfg_write(ssa_pkg::REG_CAP_SLOTS, 32'd1024);
    run_random(30, 70);
    @(negedge clk);
    hold_trig = hold_trig + 1;
    run_random(270, 70);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_modes($urandom_range(GAP_NONE, GAP_RARE), $urandom_range(GAP_NONE, GAP_RARE));
      cfg_write(ssa_pkg::REG_SLOT_BYTES, $urandom_range(0, 8191));
      cfg_write(ssa_pkg::REG_INIT_SLOTS, $urandom_range(0, 2047));
      cfg_write(ssa_pkg::REG_CAP_SLOTS, $urandom_range(0, 2047));
      run_random(150, 60);
      drain();
    end

    // Tiny region, free-heavy: deep stack of repeated frees.
    set_modes(GAP_RARE, GAP_RARE);
    cfg_write(ssa_pkg::REG_SLOT_BYTES, 32'd8);
    cfg_write(ssa_pkg::REG_INIT_SLOTS, 32'd1);
    cfg_write(ssa_pkg::REG_CAP_SLOTS, 32'd2);
    run_random(100, 30);
    drain();

    if (outcome_q.size() != 0) report("outcomes left over at end of run");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
